>>> sv/ffsi_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the free-space interval block.
// Used by the channel interfaces, the multiplier, the divider, the top level and the testbench.
package ffsi_pkg;

  // Default coordinate width in bits (signed fixed point).
  localparam int COORD_WIDTH_DEF = 32;

  // The distance bound register is a fixed 32-bit unsigned value.
  localparam int EPS_W = 32;
  localparam logic [EPS_W-1:0] DIST_RESET = 32'd65536;
  localparam logic [2*EPS_W-1:0] EPS_SQ_RESET = 64'(DIST_RESET) * 64'(DIST_RESET);

  // Interval parameters are unsigned Q1.16.
  localparam int T_FRAC = 16;
  localparam int T_W = T_FRAC + 1;
  localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC;
  localparam logic [T_W-1:0] T_ZERO = '0;

  // Operand slice width for the split multipliers.
  localparam int MUL_CHUNK = 33;

  // One result as it sits in the output register and the skid entry.
  typedef struct packed {
    logic           empty;
    logic [T_W-1:0] low;
    logic [T_W-1:0] high;
  } ffsi_result_t;

endpackage

>>> sv/ffsi_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: request, response and configuration write.
// Depends on ffsi_pkg for the default coordinate width and the result width.
interface ffsi_req_if #(parameter int COORD_WIDTH = ffsi_pkg::COORD_WIDTH_DEF);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] seg_start_x;
  logic signed [COORD_WIDTH-1:0] seg_start_y;
  logic signed [COORD_WIDTH-1:0] seg_end_x;
  logic signed [COORD_WIDTH-1:0] seg_end_y;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;

  modport source (
    output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y, point_x, point_y,
    input  ready
  );
  modport sink (
    input  valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y, point_x, point_y,
    output ready
  );
endinterface

interface ffsi_rsp_if;
  import ffsi_pkg::*;
  logic           valid;
  logic           ready;
  logic           interval_empty;
  logic [T_W-1:0] interval_low;
  logic [T_W-1:0] interval_high;

  modport source (
    output valid, interval_empty, interval_low, interval_high,
    input  ready
  );
  modport sink (
    input  valid, interval_empty, interval_low, interval_high,
    output ready
  );
endinterface

interface ffsi_cfg_if;
  import ffsi_pkg::*;
  logic             valid;
  logic             ready;
  logic [EPS_W-1:0] distance_bound;

  modport source (output valid, distance_bound, input ready);
  modport sink (input valid, distance_bound, output ready);
endinterface

>>> sv/frechet_free_space_interval.sv
`timescale 1ns / 1ps
// Free-space interval of a segment against a point: the block accepts one request
// per clock while the skid entry is free and returns one result per request in
// order. The square-root pipeline, one root bit per stage, is followed by the
// 17-stage fraction dividers. A finished result waits in the output register and
// one skid entry; the pipeline stalls only when both are full. A write to the
// distance bound is seen by every request that has not yet reached the discriminant
// multiplier, so the bound should be written only while no request is in flight.
// Depends on ffsi_pkg, ffsi_if, ffsi_mul, ffsi_sqrt and ffsi_div.
module frechet_free_space_interval #(
  parameter int COORD_WIDTH = ffsi_pkg::COORD_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  ffsi_req_if.sink     req,
  ffsi_rsp_if.source   rsp,
  ffsi_cfg_if.sink     cfg
);
  import ffsi_pkg::*;

  localparam int DW       = COORD_WIDTH + 1;
  localparam int PW       = 2 * DW;
  localparam int DDW      = 2 * DW;
  localparam int BW       = 2 * DW + 1;
  localparam int CMW      = 2 * DW;
  localparam int ESQ_W    = 2 * EPS_W;
  localparam int ED_W     = ESQ_W + DDW;
  localparam int CC_W     = 2 * CMW;
  localparam int DISC_W   = ((ED_W > CC_W) ? ED_W : CC_W) + 1;
  localparam int SQ_W     = ED_W;
  localparam int R_W      = (SQ_W + 1) / 2;
  localparam int NUM_W    = ((BW > R_W) ? BW : R_W + 1) + 1;
  localparam int SIDE_W   = 2 + DDW + BW;

  logic en;

  // Distance bound, kept as its square.
  logic [ESQ_W-1:0] eps_sq;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps_sq <= EPS_SQ_RESET;
    end else if (cfg.valid) begin
      eps_sq <= ESQ_W'(cfg.distance_bound) * ESQ_W'(cfg.distance_bound);
    end
  end

  // Input side takes a request whenever the skid entry is free.
  assign req.ready = en;

  // Stage A: differences from the segment start.
  logic signed [DW-1:0] dx_a, dy_a, px_a, py_a;
  logic                 v_a;

  always_ff @(posedge clk) begin
    if (en) begin
      dx_a <= DW'(req.seg_end_x) - DW'(req.seg_start_x);
      dy_a <= DW'(req.seg_end_y) - DW'(req.seg_start_y);
      px_a <= DW'(req.point_x) - DW'(req.seg_start_x);
      py_a <= DW'(req.point_y) - DW'(req.seg_start_y);
    end
  end

  // Stage B: the six coordinate products.
  logic signed [PW-1:0] dxx_b, dyy_b, pxdx_b, pydy_b, pxdy_b, pydx_b;
  logic                 v_b;

  always_ff @(posedge clk) begin
    if (en) begin
      dxx_b  <= dx_a * dx_a;
      dyy_b  <= dy_a * dy_a;
      pxdx_b <= px_a * dx_a;
      pydy_b <= py_a * dy_a;
      pxdy_b <= px_a * dy_a;
      pydx_b <= py_a * dx_a;
    end
  end

  // Stage C: squared length, dot product and cross product.
  logic [DDW-1:0]       d_c;
  logic signed [BW-1:0] b_c, cross_c;
  logic                 v_c;

  always_ff @(posedge clk) begin
    if (en) begin
      d_c     <= DDW'($unsigned(dxx_b)) + DDW'($unsigned(dyy_b));
      b_c     <= BW'(pxdx_b) + BW'(pydy_b);
      cross_c <= BW'(pxdy_b) - BW'(pydx_b);
    end
  end

  // Stage D: cross magnitude and zero-length check.
  logic [CMW-1:0]       cmag_d;
  logic [DDW-1:0]       d_d;
  logic signed [BW-1:0] b_d;
  logic                 dz_d;
  logic                 v_d;

  always_ff @(posedge clk) begin
    if (en) begin
      cmag_d <= CMW'(cross_c[BW-1] ? -cross_c : cross_c);
      d_d    <= d_c;
      b_d    <= b_c;
      dz_d   <= (d_c == '0);
    end
  end

  // Stages E and F: the discriminant is eps^2 * D - cross^2.
  logic [CC_W-1:0] cc_f;
  logic [ED_W-1:0] ed_f;

  ffsi_mul #(.WA(CMW), .WB(CMW)) u_mul_cc (
    .clk (clk),
    .en  (en),
    .a   (cmag_d),
    .b   (cmag_d),
    .p   (cc_f)
  );

  ffsi_mul #(.WA(ESQ_W), .WB(DDW)) u_mul_ed (
    .clk (clk),
    .en  (en),
    .a   (eps_sq),
    .b   (d_d),
    .p   (ed_f)
  );

  logic [DDW-1:0]       d_e, d_f;
  logic signed [BW-1:0] b_e, b_f;
  logic                 dz_e, dz_f;
  logic                 v_e, v_f;

  always_ff @(posedge clk) begin
    if (en) begin
      d_e  <= d_d;
      b_e  <= b_d;
      dz_e <= dz_d;
      d_f  <= d_e;
      b_f  <= b_e;
      dz_f <= dz_e;
    end
  end

  // Stage G: discriminant and its sign.
  logic signed [DISC_W-1:0] disc;
  logic [SQ_W-1:0]          sq_g;
  logic [DDW-1:0]           d_g;
  logic signed [BW-1:0]     b_g;
  logic                     dz_g, dn_g;
  logic                     v_g;

  assign disc = $signed(DISC_W'(ed_f)) - $signed(DISC_W'(cc_f));

  always_ff @(posedge clk) begin
    if (en) begin
      sq_g <= disc[SQ_W-1:0];
      dn_g <= disc[DISC_W-1];
      d_g  <= d_f;
      b_g  <= b_f;
      dz_g <= dz_f;
    end
  end

  // Valid bits of the front stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_d <= 1'b0;
      v_e <= 1'b0;
      v_f <= 1'b0;
      v_g <= 1'b0;
    end else if (en) begin
      v_a <= req.valid;
      v_b <= v_a;
      v_c <= v_b;
      v_d <= v_c;
      v_e <= v_d;
      v_f <= v_e;
      v_g <= v_f;
    end
  end

  // Square root of the discriminant.
  logic [R_W-1:0]       root_s;
  logic [SIDE_W-1:0]    side_s;
  logic                 v_s;
  logic                 dz_s, dn_s;
  logic [DDW-1:0]       d_s;
  logic signed [BW-1:0] b_s;

  ffsi_sqrt #(.IN_W(SQ_W), .SIDE_W(SIDE_W), .R_W(R_W)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_g),
    .x         (sq_g),
    .side_in   ({dz_g, dn_g, d_g, b_g}),
    .out_valid (v_s),
    .root      (root_s),
    .side_out  (side_s)
  );

  assign {dz_s, dn_s, d_s, b_s} = side_s;

  // Stage H: root numerators b - s and b + s.
  logic signed [NUM_W-1:0] num_lo_h, num_hi_h;
  logic [DDW-1:0]          d_h;
  logic                    dz_h, dn_h;
  logic                    v_h;

  always_ff @(posedge clk) begin
    if (en) begin
      num_lo_h <= NUM_W'(b_s) - NUM_W'(root_s);
      num_hi_h <= NUM_W'(b_s) + NUM_W'(root_s);
      d_h      <= d_s;
      dz_h     <= dz_s;
      dn_h     <= dn_s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_h <= 1'b0;
    end else if (en) begin
      v_h <= v_s;
    end
  end

  // Both ends divided by D and clamped to [0, 1].
  logic [T_W-1:0] q_lo, q_hi;
  logic           v_lo, v_hi;
  logic           dz_o, dn_o;

  ffsi_div #(.NUM_W(NUM_W), .DEN_W(DDW), .SIDE_W(1)) u_div_lo (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_h),
    .num       (num_lo_h),
    .den       (d_h),
    .side_in   (dz_h),
    .out_valid (v_lo),
    .quot      (q_lo),
    .side_out  (dz_o)
  );

  ffsi_div #(.NUM_W(NUM_W), .DEN_W(DDW), .SIDE_W(1)) u_div_hi (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_h),
    .num       (num_hi_h),
    .den       (d_h),
    .side_in   (dn_h),
    .out_valid (v_hi),
    .quot      (q_hi),
    .side_out  (dn_o)
  );

  // Empty when the segment has no length, the point is too far, or the ends meet.
  ffsi_result_t res_next;

  always_comb begin
    res_next.empty = dz_o || dn_o || (q_lo == q_hi);
    res_next.low   = res_next.empty ? T_ZERO : q_lo;
    res_next.high  = res_next.empty ? T_ZERO : q_hi;
  end

  // Output register plus one skid entry.
  ffsi_result_t out_r, skid_r;
  logic         out_v, skid_v;

  assign en = !skid_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (!out_v || rsp.ready) begin
      if (skid_v) begin
        out_v  <= 1'b1;
        skid_v <= 1'b0;
      end else begin
        out_v <= v_lo;
      end
    end else if (v_lo) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v || rsp.ready) begin
      out_r <= skid_v ? skid_r : res_next;
    end else if (en && v_lo) begin
      skid_r <= res_next;
    end
  end

  assign rsp.valid          = out_v;
  assign rsp.interval_empty = out_r.empty;
  assign rsp.interval_low   = out_r.low;
  assign rsp.interval_high  = out_r.high;

  // The two dividers run in lockstep.
  a_div_lockstep: assert property (@(posedge clk) disable iff (rst) v_lo == v_hi)
    else $error("divider valid bits disagree");

  // A held skid entry implies a result waiting at the output.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst) skid_v |-> out_v)
    else $error("skid entry full with output register empty");

  // An empty result carries zero ends.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
      rsp.valid && rsp.interval_empty |->
      rsp.interval_low == T_ZERO && rsp.interval_high == T_ZERO)
    else $error("empty interval with nonzero ends");

  // A non-empty interval is ordered and inside [0, 1].
  a_interval_order: assert property (@(posedge clk) disable iff (rst)
      rsp.valid && !rsp.interval_empty |->
      rsp.interval_low < rsp.interval_high && rsp.interval_high <= T_ONE)
    else $error("interval ends out of order or above one");

endmodule

>>> sv/ffsi_mul.sv
`timescale 1ns / 1ps
// Two-stage unsigned multiplier built from narrow partial products.
// Depends on ffsi_pkg for the slice width.
module ffsi_mul #(
  parameter int WA = 66,
  parameter int WB = 66
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WA-1:0]    a,
  input  logic [WB-1:0]    b,
  output logic [WA+WB-1:0] p
);
  import ffsi_pkg::*;

  localparam int CH = MUL_CHUNK;
  localparam int NA = (WA + CH - 1) / CH;
  localparam int NB = (WB + CH - 1) / CH;
  localparam int PW = WA + WB;

  logic [NA*CH-1:0] a_pad;
  logic [NB*CH-1:0] b_pad;
  logic [2*CH-1:0]  pp [NA][NB];
  logic [PW-1:0]    acc;

  assign a_pad = (NA*CH)'(a);
  assign b_pad = (NB*CH)'(b);

  // First stage: one registered product per pair of operand slices.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= a_pad[i*CH +: CH] * b_pad[j*CH +: CH];
        end
      end
    end
  end

  // Second stage: align and add the partial products.
  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (PW'(pp[i][j]) << (CH * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= acc;
    end
  end

endmodule

>>> sv/ffsi_sqrt.sv
`timescale 1ns / 1ps
// Pipelined floor square root, one result bit per stage, with a side payload.
// Stand-alone; no package contents needed beyond the common style.
module ffsi_sqrt #(
  parameter int IN_W   = 130,
  parameter int SIDE_W = 8,
  parameter int R_W    = (IN_W + 1) / 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [IN_W-1:0]   x,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [R_W-1:0]    root,
  output logic [SIDE_W-1:0] side_out
);

  localparam int X_W   = 2 * R_W;
  localparam int REM_W = R_W + 2;
  localparam int SH_W  = REM_W + 2;

  logic [X_W-1:0]    x_r    [R_W];
  logic [REM_W-1:0]  rem_r  [R_W];
  logic [R_W-1:0]    root_r [R_W];
  logic [SIDE_W-1:0] side_r [R_W];
  logic              v_r    [R_W];

  for (genvar k = 0; k < R_W; k++) begin : g_stage
    logic [X_W-1:0]    x_cur;
    logic [REM_W-1:0]  rem_cur;
    logic [R_W-1:0]    root_cur;
    logic [SIDE_W-1:0] side_cur;
    logic              v_cur;
    logic [SH_W-1:0]   rem_sh;
    logic [SH_W-1:0]   trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign x_cur    = X_W'(x);
      assign rem_cur  = '0;
      assign root_cur = '0;
      assign side_cur = side_in;
      assign v_cur    = in_valid;
    end else begin : g_next
      assign x_cur    = x_r[k-1];
      assign rem_cur  = rem_r[k-1];
      assign root_cur = root_r[k-1];
      assign side_cur = side_r[k-1];
      assign v_cur    = v_r[k-1];
    end

    // Bring down the next two radicand bits and try the next root bit.
    assign rem_sh = {rem_cur, x_cur[X_W-1 -: 2]};
    assign trial  = SH_W'({root_cur, 2'b01});
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k]    <= x_cur << 2;
        rem_r[k]  <= REM_W'(ge ? rem_sh - trial : rem_sh);
        root_r[k] <= {root_cur[R_W-2:0], ge};
        side_r[k] <= side_cur;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_cur;
      end
    end
  end

  assign out_valid = v_r[R_W-1];
  assign root      = root_r[R_W-1];
  assign side_out  = side_r[R_W-1];

endmodule

>>> sv/ffsi_div.sv
`timescale 1ns / 1ps
// Pipelined clamped fraction divider: clamp(floor(num * 2^T_FRAC / den), 0, 1.0).
// Depends on ffsi_pkg for the fraction width and the constant one.
module ffsi_div #(
  parameter int NUM_W  = 68,
  parameter int DEN_W  = 66,
  parameter int SIDE_W = 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic signed [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]         den,
  input  logic [SIDE_W-1:0]        side_in,
  output logic                     out_valid,
  output logic [ffsi_pkg::T_W-1:0] quot,
  output logic [SIDE_W-1:0]        side_out
);
  import ffsi_pkg::*;

  localparam int NS    = T_FRAC + 1;
  localparam int MAG_W = NUM_W - 1;
  localparam int CMP_W = (MAG_W > DEN_W) ? MAG_W : DEN_W;

  logic [DEN_W-1:0]  rem_r  [NS];
  logic [DEN_W-1:0]  den_r  [NS];
  logic [T_W-1:0]    q_r    [NS];
  logic              done_r [NS];
  logic [SIDE_W-1:0] side_r [NS];
  logic              v_r    [NS];

  logic num_neg;
  logic num_big;

  // Entry stage: negative numerators clamp to zero, numerators at or above
  // the denominator clamp to one.
  assign num_neg = num[NUM_W-1];
  assign num_big = !num_neg && (CMP_W'(num[MAG_W-1:0]) >= CMP_W'(den));

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= DEN_W'(num[MAG_W-1:0]);
      den_r[0]  <= den;
      q_r[0]    <= num_big ? T_ONE : T_ZERO;
      done_r[0] <= num_neg || num_big;
      side_r[0] <= side_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar k = 1; k < NS; k++) begin : g_stage
    logic [DEN_W:0] sh;
    logic [DEN_W:0] den_x;
    logic           ge;

    assign sh    = {rem_r[k-1], 1'b0};
    assign den_x = {1'b0, den_r[k-1]};
    assign ge    = (sh >= den_x);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= DEN_W'(ge ? sh - den_x : sh);
        den_r[k]  <= den_r[k-1];
        q_r[k]    <= done_r[k-1] ? q_r[k-1] : {q_r[k-1][T_W-2:0], ge};
        done_r[k] <= done_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign quot      = q_r[NS-1];
  assign side_out  = side_r[NS-1];

endmodule

>>> tb/tb_frechet_free_space_interval.sv
`timescale 1ns / 1ps
// Self-checking testbench for the free-space interval block.
// Depends on ffsi_pkg, ffsi_if and the frechet_free_space_interval RTL.
module tb_frechet_free_space_interval;
  import ffsi_pkg::*;

  localparam int CW = 32;
  localparam int LATENCY = CW + 59;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ffsi_req_if #(.COORD_WIDTH(CW)) req ();
  ffsi_rsp_if rsp ();
  ffsi_cfg_if cfg ();

  frechet_free_space_interval #(.COORD_WIDTH(CW)) u_top (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  typedef struct {
    logic signed [CW-1:0] sx, sy, ex, ey, ax, ay;
  } seg_query_t;

  logic [EPS_W-1:0] eps_model = DIST_RESET;
  ffsi_result_t interval_q[$];
  int n_errors = 0;
  int n_checked = 0;
  int n_sent = 0;
  int n_empty = 0;
  int burst_left = 0;
  bit rx_hold = 1'b0;

  // Exact integer square root, floor, by the bit-pair method.
  function automatic logic [255:0] isqrt256(input logic [255:0] x);
    logic [255:0] res;
    logic [255:0] bitv;
    logic [255:0] tmp;
    res = '0;
    for (int p = 254; p >= 0; p -= 2) begin
      bitv = 256'd1 << p;
      tmp = res + bitv;
      res = res >> 1;
      if (x >= tmp) begin
        x = x - tmp;
        res = res + bitv;
      end
    end
    return res;
  endfunction

  // floor(num * 2^16 / d) clamped to [0, 1.0] in Q1.16.
  function automatic logic [T_W-1:0] t_quotient(input logic signed [255:0] num,
                                                input logic signed [255:0] d);
    logic signed [255:0] q;
    if (num < 0) return T_ZERO;
    if (num >= d) return T_ONE;
    q = (num <<< T_FRAC) / d;
    return q[T_W-1:0];
  endfunction

  // Expected interval of a segment against a point for the current bound.
  function automatic ffsi_result_t free_interval(input seg_query_t q);
    logic signed [255:0] dx, dy, px, py, dd, b, p2, e, disc, s;
    ffsi_result_t r;
    dx = 256'(q.ex) - 256'(q.sx);
    dy = 256'(q.ey) - 256'(q.sy);
    px = 256'(q.ax) - 256'(q.sx);
    py = 256'(q.ay) - 256'(q.sy);
    dd = dx * dx + dy * dy;
    b = px * dx + py * dy;
    p2 = px * px + py * py;
    e = $signed({224'd0, eps_model});
    disc = b * b - (p2 - e * e) * dd;
    r.empty = 1'b1;
    r.low = T_ZERO;
    r.high = T_ZERO;
    if (dd != 0 && disc >= 0) begin
      s = $signed(isqrt256(disc));
      r.low = t_quotient(b - s, dd);
      r.high = t_quotient(b + s, dd);
      r.empty = (r.low == r.high);
      if (r.empty) begin
        r.low = T_ZERO;
        r.high = T_ZERO;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0d expected %0d (result %0d)", what, got, want, n_checked);
    n_errors++;
  endtask

  // Receiver stall pattern: random stalls, rarer in alternate runs of 64 results; none under rx_hold.
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (rx_hold) begin
      rsp.ready <= 1'b1;
    end else begin
      rsp.ready <= ($urandom_range(0, 99) < ((n_checked / 64) % 2 ? 95 : 60));
    end
  end

  // Result checker against the oldest expected interval.
  always @(posedge clk) begin
    ffsi_result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (interval_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = interval_q.pop_front();
        if (rsp.interval_empty !== want.empty)
          report_mismatch("interval_empty", rsp.interval_empty, want.empty);
        if (rsp.interval_low !== want.low)
          report_mismatch("interval_low", rsp.interval_low, want.low);
        if (rsp.interval_high !== want.high)
          report_mismatch("interval_high", rsp.interval_high, want.high);
        if (want.empty) n_empty++;
      end
      n_checked++;
    end
  end

  // Sends one request, with random gaps between bursts.
  task automatic send_request(input seg_query_t q);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 2) != 0) begin
        req.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    req.valid <= 1'b1;
    req.seg_start_x <= q.sx;
    req.seg_start_y <= q.sy;
    req.seg_end_x <= q.ex;
    req.seg_end_y <= q.ey;
    req.point_x <= q.ax;
    req.point_y <= q.ay;
    do @(posedge clk); while (!req.ready);
    interval_q.push_back(free_interval(q));
    n_sent++;
  endtask

  task automatic drain;
    req.valid <= 1'b0;
    burst_left = 0;
    while (interval_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic write_bound(input logic [EPS_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.distance_bound <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    eps_model = value;
  endtask

  function automatic seg_query_t make_query(input int sx, sy, ex, ey, ax, ay);
    seg_query_t q;
    q.sx = sx; q.sy = sy; q.ex = ex; q.ey = ey; q.ax = ax; q.ay = ay;
    return q;
  endfunction

  function automatic logic [CW-1:0] rand_coord(input int scale);
    logic [CW-1:0] v;
    v = $urandom;
    case (scale)
      0: return $signed(v[19:0]);
      1: return $signed(v[23:0]);
      default: return v;
    endcase
  endfunction

  // Directed corners: extremes, zero length, far point, tangent, full cover.
  task automatic test_directed;
    int unsigned mn;
    int unsigned mx;
    mn = 32'h8000_0000;
    mx = 32'h7fff_ffff;
    send_request(make_query(0, 0, 65536, 0, 32768, 0));
    send_request(make_query(0, 0, 65536, 0, 32768, 32768));
    send_request(make_query(0, 0, 65536, 0, 32768, 131072));
    send_request(make_query(0, 0, 65536, 0, 32768, 65536));
    send_request(make_query(5, 7, 5, 7, 5, 7));
    send_request(make_query(0, 0, 1048576, 0, -65536, 0));
    send_request(make_query(0, 0, 1048576, 0, 2097152, 0));
    send_request(make_query(0, 0, 1048576, 0, 1114112, 0));
    send_request(make_query(mn, mn, mx, mx, 0, 0));
    send_request(make_query(mx, mx, mn, mn, mx, mn));
    send_request(make_query(mn, mx, mx, mn, mn, mn));
    send_request(make_query(mx, 0, mn, 0, -1, -1));
    send_request(make_query(-1, -1, 1, 1, 0, 0));
    send_request(make_query(0, 0, 1, 0, 0, 0));
    send_request(make_query(mn, mn, mn, mn, mx, mx));
    send_request(make_query(-65536, 0, 65536, 0, 0, 65535));
    drain();
  endtask

  // Random requests; most points are offset from the segment's midpoint, some with x set to the end's x.
  task automatic test_random(input int count);
    seg_query_t q;
    int scale;
    logic [CW-1:0] t;
    for (int i = 0; i < count; i++) begin
      scale = $urandom_range(0, 9) < 7 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
      q.sx = rand_coord(scale);
      q.sy = rand_coord(scale);
      q.ex = rand_coord(scale);
      q.ey = rand_coord(scale);
      if ($urandom_range(0, 9) < 7) begin
        t = $urandom_range(0, 65536);
        q.ax = q.sx + ((q.ex - q.sx) >>> 1) + $signed(rand_coord(0) >>> 4);
        q.ay = q.sy + ((q.ey - q.sy) >>> 1) + $signed(rand_coord(0) >>> 4);
        if (t[0]) q.ax = q.ex;
      end else begin
        q.ax = rand_coord(scale);
        q.ay = rand_coord(scale);
      end
      if ($urandom_range(0, 19) == 0) begin
        q.ex = q.sx;
        q.ey = q.sy;
      end
      send_request(q);
    end
    drain();
  endtask

  // Bound settings from zero to the maximum, including the reset value, each followed by a random bound.
  task automatic test_bound_sweep;
    logic [EPS_W-1:0] bounds[6];
    bounds = '{32'd0, 32'd1, 32'h0004_0000, 32'hffff_ffff, 32'h0000_8000, DIST_RESET};
    foreach (bounds[k]) begin
      write_bound(bounds[k]);
      test_random(k == 3 ? 30 : 50);
      write_bound($urandom_range(32'h0000_1000, 32'h0010_0000));
      test_random(30);
    end
  endtask

  initial begin
    req.valid = 1'b0;
    req.seg_start_x = '0;
    req.seg_start_y = '0;
    req.seg_end_x = '0;
    req.seg_end_y = '0;
    req.point_x = '0;
    req.point_y = '0;
    cfg.valid = 1'b0;
    cfg.distance_bound = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(50);
    test_bound_sweep();
    rx_hold = 1'b1;
    test_random(20);
    $display("covered %0d requests, %0d results checked, %0d empty intervals",
             n_sent, n_checked, n_empty);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> sim.f
sv/ffsi_pkg.sv
sv/ffsi_if.sv
sv/ffsi_mul.sv
sv/ffsi_sqrt.sv
sv/ffsi_div.sv
sv/frechet_free_space_interval.sv
tb/tb_frechet_free_space_interval.sv
